FILE: design/wto_pkg.sv
// ----------------------------------------------------------------------------
// wto_pkg: shared types and constants for the wavetable oscillator
// Field widths, configuration register indexes, operation codes, the
// controller state encoding and the command and status bundles.
// ----------------------------------------------------------------------------
package wto_pkg;

  // Fixed field widths
  localparam int TBL_IDX_W  = 12;
  localparam int SAMPLE_W   = 16;
  localparam int FREQ_W     = 32;
  localparam int SPR_W      = 32;
  localparam int TSIZE_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // freq * size_per_rate is Q16.16 times Q8.24, so it carries 40 fraction bits
  localparam int PROD_FRAC  = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_FREQ    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_PER_RATE = 2'd3;

  // Configuration reset values
  localparam logic                  RST_FREQ_MODE     = 1'b0;
  localparam logic [FREQ_W-1:0]     RST_CONST_FREQ    = 32'd65536000;
  localparam logic [TSIZE_W-1:0]    RST_TABLE_SIZE    = 13'd4096;
  localparam logic [SPR_W-1:0]      RST_SIZE_PER_RATE = 32'd1558286;

  // Frequency source select
  localparam logic FREQ_CONST = 1'b0;
  localparam logic FREQ_INPUT = 1'b1;

  // Operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Controller states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_INC  = 8'b0000_0100,
    S_WRAP = 8'b0000_1000,
    S_RED  = 8'b0001_0000,
    S_READ = 8'b0010_0000,
    S_MULD = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic acc_tick;   // tick transaction accepted: capture frequency
    logic acc_write;  // table write transaction accepted
    logic mul;        // frequency times size_per_rate
    logic inc;        // scale, clamp and add increment to phase
    logic wrap;       // fold sum into [0, size)
    logic red;        // one step of the long modulo reduction
    logic rd;         // read the two table entries
    logic muld;       // slope times fraction
    logic ld_out;     // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_red;   // sum too far above size for the single subtract
    logic red_last;   // last reduction step
    logic out_free;   // output register can take a new sample
  } sts_t;

endpackage

FILE: design/wto_datapath.sv
// ----------------------------------------------------------------------------
// wto_datapath: phase accumulator, sample store and interpolator
// Holds the configuration registers, the phase, the wave store and the
// output register, and performs the steps the controller commands.
// ----------------------------------------------------------------------------
module wto_datapath import wto_pkg::*; #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [TBL_IDX_W-1:0]         in_table_index,
  input  logic signed [SAMPLE_W-1:0]   in_table_value,
  input  logic signed [FREQ_W-1:0]     in_freq_sample,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [SAMPLE_W-1:0]   out_sample
);

  localparam int IW        = $clog2(TABLE_DEPTH);
  localparam int SIZE_W    = $clog2(TABLE_DEPTH + 1);
  localparam int PHASE_W   = IW + FRACTION_BITS;
  localparam int SQ_W      = SIZE_W + FRACTION_BITS;
  localparam int REM_W     = PHASE_W + 1;
  localparam int SUM_W     = PHASE_W + 2;
  localparam int INC_SHIFT = PROD_FRAC - FRACTION_BITS;
  localparam int K_W       = $clog2(IW + 1);
  localparam int P_W       = FRACTION_BITS + SAMPLE_W + 2;
  localparam logic signed [P_W-1:0] HALF = P_W'(1) << (FRACTION_BITS - 1);

  // Configuration registers
  logic                     freq_mode_r;
  logic [FREQ_W-1:0]        const_freq_r;
  logic [TSIZE_W-1:0]       table_size_r;
  logic [SPR_W-1:0]         spr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_mode_r  <= RST_FREQ_MODE;
      const_freq_r <= RST_CONST_FREQ;
      table_size_r <= RST_TABLE_SIZE;
      spr_r        <= RST_SIZE_PER_RATE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FREQ_MODE:     freq_mode_r  <= cfg_data[0];
        CFG_CONST_FREQ:    const_freq_r <= cfg_data[FREQ_W-1:0];
        CFG_TABLE_SIZE:    table_size_r <= cfg_data[TSIZE_W-1:0];
        CFG_SIZE_PER_RATE: spr_r        <= cfg_data[SPR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective table size, clamped to [2, TABLE_DEPTH]
  logic [SIZE_W-1:0] size;
  logic [SQ_W-1:0]   size_q;
  logic [REM_W-1:0]  size_q_ext;

  always_comb begin
    if (table_size_r < TSIZE_W'(2)) begin
      size = SIZE_W'(2);
    end else if (32'(table_size_r) > 32'(TABLE_DEPTH)) begin
      size = SIZE_W'(TABLE_DEPTH);
    end else begin
      size = SIZE_W'(table_size_r);
    end
  end

  assign size_q     = {size, FRACTION_BITS'(0)};
  assign size_q_ext = REM_W'(size_q);

  // Frequency magnitude and sign captured on a tick transaction
  logic [FREQ_W-1:0] freq_sel;
  logic [FREQ_W-1:0] mag_nxt;
  logic [FREQ_W-1:0] mag_r;
  logic              neg_r;

  assign freq_sel = (freq_mode_r == FREQ_INPUT) ? in_freq_sample : const_freq_r;
  assign mag_nxt  = freq_sel[FREQ_W-1] ? (~freq_sel + FREQ_W'(1)) : freq_sel;

  always_ff @(posedge clk) begin
    if (cmd.acc_tick) begin
      mag_r <= mag_nxt;
      neg_r <= freq_sel[FREQ_W-1];
    end
  end

  // Increment product
  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= 64'(mag_r) * 64'(spr_r);
    end
  end

  // Scale, clamp and add to phase
  logic [63:0]              prod_sh;
  logic [63:0]              inc_lim;
  logic [PHASE_W-1:0]       inc_mag;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic [PHASE_W-1:0]       phase_r;

  assign prod_sh = prod_r >> INC_SHIFT;
  assign inc_lim = 64'(size_q) - 64'd1;
  assign inc_mag = (prod_sh > inc_lim) ? PHASE_W'(inc_lim) : PHASE_W'(prod_sh);
  assign sum_nxt = neg_r ? ($signed(SUM_W'(phase_r)) - $signed(SUM_W'(inc_mag)))
                         : ($signed(SUM_W'(phase_r)) + $signed(SUM_W'(inc_mag)));

  always_ff @(posedge clk) begin
    if (cmd.inc) begin
      sum_r <= sum_nxt;
    end
  end

  // Wrap: add size to a negative sum, subtract it once from a small overshoot
  logic [REM_W-1:0]    sum_pos;
  logic [REM_W-1:0]    diff1;
  logic                sum_neg;
  logic [PHASE_W-1:0]  wrap_val;

  assign sum_neg = sum_r[SUM_W-1];
  assign sum_pos = REM_W'(sum_r);
  assign diff1   = sum_pos - size_q_ext;

  always_comb begin
    if (sum_neg) begin
      wrap_val = PHASE_W'(sum_r + $signed(SUM_W'(size_q)));
    end else if (sum_pos < size_q_ext) begin
      wrap_val = PHASE_W'(sum_pos);
    end else begin
      wrap_val = PHASE_W'(diff1);
    end
  end

  assign sts.need_red = !sum_neg && (sum_pos >= size_q_ext) && (diff1 >= size_q_ext);

  // Long reduction: restoring modulo, one quotient bit per cycle
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic [K_W-1:0]   k_r;

  assign rem_nxt = ((rem_r >> k_r) >= size_q_ext) ? (rem_r - (size_q_ext << k_r)) : rem_r;
  assign sts.red_last = (k_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.wrap) begin
      rem_r <= sum_pos;
      k_r   <= K_W'(IW - 1);
    end else if (cmd.red) begin
      rem_r <= rem_nxt;
      k_r   <= k_r - K_W'(1);
    end
  end

  // Phase register
  logic [PHASE_W-1:0] phase_nxt;

  always_comb begin
    phase_nxt = phase_r;
    if (cmd.wrap && !sts.need_red) begin
      phase_nxt = wrap_val;
    end else if (cmd.red && sts.red_last) begin
      phase_nxt = PHASE_W'(rem_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Wave store: one write port, two registered read ports
  logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];
  logic [IW-1:0]              ipart;
  logic [IW-1:0]              inext;
  logic signed [SAMPLE_W-1:0] x0_r;
  logic signed [SAMPLE_W-1:0] x1_r;
  logic [FRACTION_BITS-1:0]   frac_r;

  assign ipart = phase_r[PHASE_W-1:FRACTION_BITS];
  assign inext = ((SIZE_W'(ipart) + SIZE_W'(1)) == size) ? '0 : (ipart + IW'(1));

  always_ff @(posedge clk) begin
    if (cmd.acc_write && (32'(in_table_index) < 32'(TABLE_DEPTH))) begin
      wave_mem[IW'(in_table_index)] <= in_table_value;
    end
    if (cmd.rd) begin
      x0_r   <= wave_mem[ipart];
      x1_r   <= wave_mem[inext];
      frac_r <= phase_r[FRACTION_BITS-1:0];
    end
  end

  // Slope times fraction
  logic signed [SAMPLE_W:0] diff;
  logic signed [P_W-1:0]    pd_r;

  assign diff = $signed({x1_r[SAMPLE_W-1], x1_r}) - $signed({x0_r[SAMPLE_W-1], x0_r});

  always_ff @(posedge clk) begin
    if (cmd.muld) begin
      pd_r <= P_W'(diff) * $signed(P_W'({1'b0, frac_r}));
    end
  end

  // Round half up and add to the lower entry
  logic signed [P_W-1:0]      step;
  logic signed [P_W-1:0]      val;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  assign step       = (pd_r + HALF) >>> FRACTION_BITS;
  assign val        = step + P_W'(x0_r);
  assign sample_nxt = val[SAMPLE_W-1:0];

  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // Checks
  a_wrap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wrap && !sts.need_red |=> REM_W'(phase_r) < size_q_ext)
    else $error("phase outside table after wrap");

  a_red_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.red && sts.red_last |=> REM_W'(phase_r) < size_q_ext)
    else $error("phase outside table after reduction");

  a_interp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (sample_nxt >= x0_r && sample_nxt <= x1_r)
                || (sample_nxt <= x0_r && sample_nxt >= x1_r))
    else $error("interpolated sample outside its two entries");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=> out_valid_r)
    else $error("loaded sample not presented");

endmodule

FILE: design/wto_ctrl.sv
// ----------------------------------------------------------------------------
// wto_ctrl: sequencing state machine for the wavetable oscillator
// Accepts transactions, steps a tick through the datapath and waits on the
// output register.
// ----------------------------------------------------------------------------
module wto_ctrl import wto_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_operation,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == OP_WRITE) begin
            cmd.acc_write = 1'b1;
          end else begin
            cmd.acc_tick = 1'b1;
            state_nxt    = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_INC;
      end
      S_INC: begin
        cmd.inc   = 1'b1;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = sts.need_red ? S_RED : S_READ;
      end
      S_RED: begin
        cmd.red = 1'b1;
        if (sts.red_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.muld  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_tick |=> !in_ready)
    else $error("ready while a tick is in progress");

  a_red_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RED && sts.red_last |=> state_r == S_READ)
    else $error("reduction did not finish");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && !sts.out_free |=> state_r == S_OUT)
    else $error("left output state with register still full");

endmodule

FILE: design/wavetable_oscillator.sv
// Sequence: an accepted tick steps through multiply, increment, wrap, table
//   read, slope multiply and output load; after a table size change a tick may
//   also need the long modulo reduction. Table writes are taken while idle; a
//   new tick only once the last is loaded, which waits on a free output.
// Reset: synchronous, active low; phase to zero, registers to defaults,
//   table contents undefined until written.
// ----------------------------------------------------------------------------
// wavetable_oscillator: wavetable oscillator with linear interpolation
// Loads a 16-bit sample table and produces one interpolated sample per
// tick from a fixed-point phase accumulator.
// ----------------------------------------------------------------------------
module wavetable_oscillator import wto_pkg::*; #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int FRACTION_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [TBL_IDX_W-1:0]       in_table_index,
  input  logic signed [SAMPLE_W-1:0] in_table_value,
  input  logic signed [FREQ_W-1:0]   in_freq_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  wto_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Phase, store and interpolation
  wto_datapath #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .in_freq_sample (in_freq_sample),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_sample     (out_sample)
  );

endmodule
